// ----- rtl/drti_pkg.sv -----
// ----------------------------------------------------------------------------
// Double round to integral package
// Shared types and constants for the round-to-integral pipeline.
// ----------------------------------------------------------------------------
package drti_pkg;

    localparam logic [1:0] MODE_TRUNC = 2'd0;
    localparam logic [1:0] MODE_FLOOR = 2'd1;
    localparam logic [1:0] MODE_CEIL  = 2'd2;
    localparam logic [1:0] MODE_NEAR  = 2'd3;

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [10:0] EXP_BIAS  = 11'd1023;
    localparam logic [10:0] EXP_BIG   = 11'd1075;

    typedef enum logic [1:0] {
        K_PASS,
        K_SMALL,
        K_NORMAL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  mode;
        logic [5:0]  shift;
        logic [63:0] x;
    } t_s1;

    typedef struct packed {
        logic [63:0] value;
        logic [63:0] unit;
        logic        up;
    } t_s2;

endpackage

// ----- rtl/double_round_to_integral.sv -----
// ----------------------------------------------------------------------------
// Double round to integral
// Rounds an IEEE-754 double to an integral value in one of four modes.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata fields (low bit up)
// s_axis   in         value_bits[63:0]; tuser op[1:0]
// m_axis   out        result_bits[63:0]
// One word enters per cycle while no stall holds the first stage; a result
// word is valid once its input has passed through every stage below.
// The three stages are decode, mask and increment, each registered.
// A stall on the output holds every full stage; empty stages still fill.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module double_round_to_integral (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value_bits
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result_bits
);

    logic          r_v1, r_v2, r_v3;
    drti_pkg::t_s1 r_s1, n_s1;
    drti_pkg::t_s2 r_s2, n_s2;
    logic [63:0]   r_res, n_res;
    logic          w_en3, w_en2, w_en1;

    assign w_en3 = !r_v3 || m_axis_tready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_res;

    drti_decode u_dec (.i_mode(s_axis_tuser), .i_x(s_axis_tdata), .o_s1(n_s1));
    drti_mask   u_msk (.i_s1(r_s1), .o_s2(n_s2));

    assign n_res = r_s2.up ? (r_s2.value + r_s2.unit) : r_s2.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
        if (w_en1) r_s1 <= n_s1;
        if (w_en2) r_s2 <= n_s2;
        if (w_en3) r_res <= n_res;
    end

endmodule

// ----- rtl/drti_decode.sv -----
// ----------------------------------------------------------------------------
// Decode stage
// Classifies the operand and computes the fraction width.
// ----------------------------------------------------------------------------
module drti_decode (
    input  logic               [1:0]  i_mode,
    input  logic               [63:0] i_x,
    output drti_pkg::t_s1             o_s1
);

    logic [10:0] w_exp;
    logic [10:0] w_fw;

    assign w_exp = i_x[62:52];
    assign w_fw  = drti_pkg::EXP_BIG - w_exp;

    always_comb begin
        o_s1.mode  = i_mode;
        o_s1.x     = i_x;
        o_s1.shift = w_fw[5:0];
        if (w_exp >= drti_pkg::EXP_BIG) begin
            o_s1.kind = drti_pkg::K_PASS;
        end else if (w_exp < drti_pkg::EXP_BIAS) begin
            o_s1.kind = drti_pkg::K_SMALL;
        end else begin
            o_s1.kind = drti_pkg::K_NORMAL;
        end
    end

endmodule

// ----- rtl/drti_mask.sv -----
// ----------------------------------------------------------------------------
// Mask stage
// Masks fraction bits, decides the increment and handles special cases.
// ----------------------------------------------------------------------------
module drti_mask (
    input  drti_pkg::t_s1 i_s1,
    output drti_pkg::t_s2 o_s2
);

    logic [63:0] w_unit;
    logic [63:0] w_fmask;
    logic [63:0] w_frac;
    logic        w_neg;
    logic        w_nz;
    logic        w_fnz;
    logic [63:0] w_zero;

    always_comb begin
        w_unit  = 64'd1 << i_s1.shift;
        w_fmask = w_unit - 64'd1;
        w_frac  = i_s1.x & w_fmask;
        w_neg   = i_s1.x[63];
        w_nz    = (i_s1.x[62:0] != 63'd0);
        w_fnz   = (w_frac != 64'd0);
        w_zero  = i_s1.x & drti_pkg::SIGN_MASK;
        o_s2.unit = w_unit;
        o_s2.up   = 1'b0;
        o_s2.value = i_s1.x;
        case (i_s1.kind)
            drti_pkg::K_PASS: begin
                o_s2.value = i_s1.x;
            end
            drti_pkg::K_SMALL: begin
                o_s2.value = w_zero;
                case (i_s1.mode)
                    drti_pkg::MODE_FLOOR: begin
                        if (w_neg && w_nz) o_s2.value = drti_pkg::SIGN_MASK | drti_pkg::ONE_BITS;
                    end
                    drti_pkg::MODE_CEIL: begin
                        if (!w_neg && w_nz) o_s2.value = drti_pkg::ONE_BITS;
                    end
                    drti_pkg::MODE_NEAR: begin
                        if (i_s1.x[62:52] == drti_pkg::EXP_BIAS - 11'd1) begin
                            o_s2.value = w_zero | drti_pkg::ONE_BITS;
                        end
                    end
                    default: begin
                        o_s2.value = w_zero;
                    end
                endcase
            end
            default: begin
                o_s2.value = i_s1.x & ~w_fmask;
                case (i_s1.mode)
                    drti_pkg::MODE_FLOOR: o_s2.up = w_neg && w_fnz;
                    drti_pkg::MODE_CEIL:  o_s2.up = !w_neg && w_fnz;
                    drti_pkg::MODE_NEAR:  o_s2.up = ((w_frac & (w_unit >> 1)) != 64'd0);
                    default:              o_s2.up = 1'b0;
                endcase
            end
        endcase
    end

endmodule
